FILE: rtl/bpr_pkg.sv
// Package with the state encoding and constants of the buffer pool replacement unit.
`timescale 1ns / 1ps
`default_nettype none
package bpr_pkg;

  typedef enum logic [1:0] {
    POL_LRU   = 2'd0,
    POL_CFLRU = 2'd1,
    POL_SIEVE = 2'd2,
    POL_NONE  = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    CFG_POLICY   = 2'd0,
    CFG_CAPACITY = 2'd1,
    CFG_DIVISOR  = 2'd2
  } cfg_reg_t;

  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PICK,
    ST_SWEEP,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/buffer_pool_replacement_unit.sv
// Top level of the buffer pool replacement unit: sequencer, entry store and counters.
// The time from accept to result beat grows with occupancy and is
// set by one comparator that visits one list entry per cycle in the search, the
// SIEVE hand sweep or clean-first window scan, and the shift that closes the gap.
// One access at a time: in_ready is low from accept until the result beat is taken.
// Reset (synchronous, rst_n low): list empty, marks, hand and counters zero,
// registers back to LRU, capacity 16, divisor 4. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module buffer_pool_replacement_unit #(
  parameter int POOL_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_page_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [3:0]       out_hit_position,
  output logic             out_evicted_valid,
  output logic [31:0]      out_evicted_page,
  output logic             out_evicted_dirty,
  output logic [31:0]      out_hit_total,
  output logic [31:0]      out_read_miss_total,
  output logic [31:0]      out_write_miss_total
);
  import bpr_pkg::*;

  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);

  // Configuration registers.
  logic [1:0] policy_r;
  logic [4:0] capacity_r;
  logic [4:0] divisor_r;

  // Entry store and list state.
  logic [31:0]           ids_r [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] dirty_r;
  logic [POOL_DEPTH-1:0] visit_r;
  logic [CW-1:0]         occ_r;
  logic [IW-1:0]         hand_r;
  logic [31:0]           hits_r, rmiss_r, wmiss_r;

  // Access registers.
  state_t      state_r, state_nxt;
  logic        op_r;
  logic [31:0] page_r;
  logic [IW-1:0] idx_r;     // scan or shift position
  logic [IW-1:0] pos_r;     // hit or victim position
  logic [CW-1:0] win_r;     // last CFLRU window position
  logic        hit_r;
  logic        ev_r;
  logic [31:0] ev_page_r;
  logic        ev_dirty_r;
  logic        mv_dirty_r, mv_visit_r;
  logic [CW-1:0] sweep_r;

  // Effective capacity, clamped to 1..POOL_DEPTH.
  logic [CW-1:0] eff_cap;
  always_comb begin
    if (capacity_r == 5'd0) eff_cap = CW'(1);
    else if (32'(capacity_r) > 32'(POOL_DEPTH)) eff_cap = CW'(POOL_DEPTH);
    else eff_cap = CW'(capacity_r);
  end

  // Integer quotient occ/div by a small table over the narrow values, capped at occ-1.
  logic [CW-1:0] win_calc;
  always_comb begin
    logic [4:0] dv;
    dv = (divisor_r == 5'd0) ? 5'd1 : divisor_r;
    win_calc = '0;
    for (int q = 1; q <= POOL_DEPTH; q++) begin
      if (32'(q) * 32'(dv) <= 32'(occ_r)) win_calc = CW'(q);
    end
    if (occ_r != '0 && win_calc > occ_r - CW'(1)) win_calc = occ_r - CW'(1);
  end

  logic [IW-1:0] idx_inc;
  logic          idx_last;
  logic [IW-1:0] hand_start;
  assign idx_inc  = idx_r + IW'(1);
  assign idx_last = (CW'(idx_r) + CW'(1)) >= occ_r;
  assign hand_start = (CW'(hand_r) >= occ_r) ? '0 : hand_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (occ_r != '0 && ids_r[idx_r] == page_r) begin
          if (policy_r == POL_LRU || policy_r == POL_CFLRU) state_nxt = ST_SHIFT;
          else state_nxt = ST_DONE;
        end else if (occ_r == '0 || idx_last) begin
          if (policy_r == POL_NONE) state_nxt = ST_DONE;
          else if (occ_r >= eff_cap) begin
            case (policy_r)
              POL_CFLRU: state_nxt = ST_PICK;
              POL_SIEVE: state_nxt = ST_SWEEP;
              default:   state_nxt = ST_SHIFT;
            endcase
          end else state_nxt = ST_DONE;
        end
      end
      ST_PICK: begin
        if (!dirty_r[idx_r] || CW'(idx_r) >= win_r) state_nxt = ST_SHIFT;
      end
      ST_SWEEP: begin
        if (!visit_r[idx_r] || sweep_r >= occ_r) state_nxt = ST_SHIFT;
      end
      ST_SHIFT:  if (idx_last) state_nxt = ST_DONE;
      ST_DONE:   if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_DONE);
  end

  assign out_hit              = hit_r;
  assign out_hit_position     = hit_r ? 4'(pos_r) : 4'd0;
  assign out_evicted_valid    = ev_r;
  assign out_evicted_page     = ev_page_r;
  assign out_evicted_dirty    = ev_dirty_r;
  assign out_hit_total        = hits_r;
  assign out_read_miss_total  = rmiss_r;
  assign out_write_miss_total = wmiss_r;

  // Entry store: the id array has no reset, only its filled part is read.
  always_ff @(posedge clk) begin
    if (state_r == ST_SHIFT) begin
      if (!idx_last) ids_r[idx_r] <= ids_r[idx_inc];
      else ids_r[idx_r] <= page_r;
    end else if (state_r == ST_SEARCH && !(occ_r != '0 && ids_r[idx_r] == page_r) &&
                 (occ_r == '0 || idx_last) && policy_r != POL_NONE &&
                 occ_r < eff_cap) begin
      ids_r[IW'(occ_r)] <= page_r;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      policy_r   <= POL_LRU;
      capacity_r <= 5'd16;
      divisor_r  <= 5'd4;
      dirty_r    <= '0;
      visit_r    <= '0;
      occ_r      <= '0;
      hand_r     <= '0;
      hits_r     <= '0;
      rmiss_r    <= '0;
      wmiss_r    <= '0;
      hit_r      <= 1'b0;
      ev_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              CFG_POLICY:   policy_r   <= cfg_data[1:0];
              CFG_CAPACITY: capacity_r <= cfg_data[4:0];
              CFG_DIVISOR:  divisor_r  <= cfg_data[4:0];
              default: ;
            endcase
          end
          if (in_valid) begin
            op_r       <= in_operation;
            page_r     <= in_page_id;
            idx_r      <= '0;
            hit_r      <= 1'b0;
            ev_r       <= 1'b0;
            ev_page_r  <= '0;
            ev_dirty_r <= 1'b0;
          end
        end
        ST_SEARCH: begin
          if (occ_r != '0 && ids_r[idx_r] == page_r) begin
            hit_r  <= 1'b1;
            pos_r  <= idx_r;
            hits_r <= hits_r + 32'd1;
            mv_dirty_r <= dirty_r[idx_r] | (op_r == OP_WRITE);
            mv_visit_r <= visit_r[idx_r];
            if (op_r == OP_WRITE) dirty_r[idx_r] <= 1'b1;
            if (policy_r == POL_SIEVE) visit_r[idx_r] <= 1'b1;
          end else if (occ_r == '0 || idx_last) begin
            if (op_r == OP_WRITE) wmiss_r <= wmiss_r + 32'd1;
            else rmiss_r <= rmiss_r + 32'd1;
            mv_dirty_r <= op_r;
            mv_visit_r <= 1'b0;
            win_r   <= win_calc;
            sweep_r <= '0;
            if (policy_r != POL_NONE) begin
              if (occ_r >= eff_cap) begin
                ev_r <= 1'b1;
                idx_r <= (policy_r == POL_SIEVE) ? hand_start : '0;
                pos_r <= '0;
                // LRU always gives up the oldest entry.
                if (policy_r == POL_LRU) begin
                  ev_page_r  <= ids_r[0];
                  ev_dirty_r <= dirty_r[0];
                end
              end else begin
                dirty_r[IW'(occ_r)] <= op_r;
                visit_r[IW'(occ_r)] <= 1'b0;
                occ_r <= occ_r + CW'(1);
              end
            end
          end else idx_r <= idx_inc;
        end
        ST_PICK: begin
          if (!dirty_r[idx_r] || CW'(idx_r) >= win_r) begin
            if (!dirty_r[idx_r]) pos_r <= idx_r;
            idx_r <= dirty_r[idx_r] ? '0 : idx_r;
            ev_page_r  <= dirty_r[idx_r] ? ids_r[0] : ids_r[idx_r];
            ev_dirty_r <= dirty_r[idx_r] ? dirty_r[0] : 1'b0;
          end else idx_r <= idx_inc;
        end
        ST_SWEEP: begin
          if (!visit_r[idx_r] || sweep_r >= occ_r) begin
            hand_r     <= idx_r;
            pos_r      <= idx_r;
            ev_page_r  <= ids_r[idx_r];
            ev_dirty_r <= dirty_r[idx_r];
          end else begin
            visit_r[idx_r] <= 1'b0;
            idx_r   <= idx_last ? '0 : idx_inc;
            sweep_r <= sweep_r + CW'(1);
          end
        end
        ST_SHIFT: begin
          if (!idx_last) begin
            dirty_r[idx_r] <= dirty_r[idx_inc];
            visit_r[idx_r] <= visit_r[idx_inc];
            idx_r <= idx_inc;
          end else begin
            dirty_r[idx_r] <= mv_dirty_r;
            visit_r[idx_r] <= mv_visit_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bpr_checker.sv
// Port-level checker for the buffer pool replacement unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bpr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [3:0]  out_hit_position,
  input wire logic        out_evicted_valid,
  input wire logic [31:0] out_hit_total
);

  // No new access while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  // A hit result never also reports an eviction.
  a_hit_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid) else $error("hit with eviction");

  // A miss reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_position == 4'd0) else $error("miss position");

  // Result stays put while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_total))
    else $error("result changed while stalled");

  // An accepted access produces no result on the very next edge.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

endmodule

bind buffer_pool_replacement_unit bpr_checker u_bpr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
  .out_hit_position(out_hit_position), .out_evicted_valid(out_evicted_valid),
  .out_hit_total(out_hit_total)
);
`default_nettype wire

FILE: tb/buffer_pool_replacement_unit_tb.sv
// Testbench for the buffer pool replacement unit: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module buffer_pool_replacement_unit_tb;
  import bpr_pkg::*;

  localparam int DEPTH = 16;
  localparam int DRAIN_CYCLES = 3 * DEPTH + 12;
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic        hit;
    logic [3:0]  hit_position;
    logic        evicted_valid;
    logic [31:0] evicted_page;
    logic        evicted_dirty;
    logic [31:0] hit_total;
    logic [31:0] read_miss_total;
    logic [31:0] write_miss_total;
  } access_result_t;

  typedef struct {
    bit             is_cfg;
    cfg_reg_t       reg_index;
    logic [31:0]    reg_data;
    logic           op;
    logic [31:0]    page;
    bit             typed;
    access_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  logic [31:0] in_page_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [3:0] out_hit_position;
  logic out_evicted_valid;
  logic [31:0] out_evicted_page;
  logic out_evicted_dirty;
  logic [31:0] out_hit_total;
  logic [31:0] out_read_miss_total;
  logic [31:0] out_write_miss_total;

  buffer_pool_replacement_unit #(.POOL_DEPTH(DEPTH)) dut (.*);

  // Mirror of the pool state and registers.
  policy_t     pol_m;
  logic [4:0]  cap_m;
  logic [4:0]  div_m;
  logic [31:0] page_m [DEPTH];
  logic        dirty_m [DEPTH];
  logic        visited_m [DEPTH];
  int          occ_m;
  int          hand_m;
  logic [31:0] hits_m, rmiss_m, wmiss_m;

  access_result_t pending_results[$];
  int errors = 0;
  int accesses = 0;
  int results_seen = 0;
  int evictions_seen = 0;
  bit hold_req = 1'b0;
  bit no_gaps = 1'b0;
  stim_row_t table_rows[$];

  initial begin
    forever #5 clk = ~clk;
  end

  // Drop entry pos and close the gap.
  function automatic void pool_remove(int pos);
    for (int k = pos; k + 1 < occ_m; k++) begin
      page_m[k] = page_m[k + 1];
      dirty_m[k] = dirty_m[k + 1];
      visited_m[k] = visited_m[k + 1];
    end
    occ_m--;
  endfunction

  function automatic void pool_append(logic [31:0] id, logic d, logic v);
    if (occ_m < DEPTH) begin
      page_m[occ_m] = id;
      dirty_m[occ_m] = d;
      visited_m[occ_m] = v;
      occ_m++;
    end
  endfunction

  // Works out the result of one access and advances the mirrored pool.
  function automatic access_result_t predict_access(logic op, logic [31:0] id);
    access_result_t r;
    int pos;
    int victim;
    int cap;
    int last;
    int dv;
    bit found;
    logic d, v;
    r = '0;
    pos = 0;
    found = 1'b0;
    for (int k = 0; k < occ_m; k++) begin
      if (!found && page_m[k] == id) begin
        found = 1'b1;
        pos = k;
      end
    end
    if (found) begin
      hits_m++;
      if (op == OP_WRITE) dirty_m[pos] = 1'b1;
      if (pol_m == POL_LRU || pol_m == POL_CFLRU) begin
        d = dirty_m[pos];
        v = visited_m[pos];
        pool_remove(pos);
        pool_append(id, d, v);
      end else if (pol_m == POL_SIEVE) begin
        visited_m[pos] = 1'b1;
      end
    end else begin
      if (op == OP_WRITE) wmiss_m++;
      else rmiss_m++;
      if (pol_m != POL_NONE) begin
        cap = (cap_m == 0) ? 1 : ((cap_m > DEPTH) ? DEPTH : int'(cap_m));
        if (occ_m >= cap) begin
          victim = 0;
          if (pol_m == POL_CFLRU) begin
            dv = (div_m == 0) ? 1 : int'(div_m);
            last = occ_m / dv;
            if (last > occ_m - 1) last = occ_m - 1;
            for (int k = last; k >= 0; k--) begin
              if (!dirty_m[k]) victim = k;
            end
          end else if (pol_m == POL_SIEVE) begin
            if (hand_m >= occ_m) hand_m = 0;
            for (int s = 0; s <= occ_m; s++) begin
              if (!visited_m[hand_m]) break;
              visited_m[hand_m] = 1'b0;
              hand_m = (hand_m + 1 >= occ_m) ? 0 : hand_m + 1;
            end
            victim = hand_m;
          end
          r.evicted_valid = 1'b1;
          r.evicted_page = page_m[victim];
          r.evicted_dirty = dirty_m[victim];
          pool_remove(victim);
        end
        pool_append(id, op, 1'b0);
      end
    end
    r.hit = found;
    r.hit_position = found ? pos[3:0] : 4'd0;
    r.hit_total = hits_m;
    r.read_miss_total = rmiss_m;
    r.write_miss_total = wmiss_m;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
    errors++;
  endtask

  // Result checker: each returned beat against the oldest expectation.
  always @(posedge clk) begin
    access_result_t w;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(results_seen), 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_evicted_valid) evictions_seen++;
        if (out_hit !== w.hit) report_mismatch("hit", 32'(out_hit), 32'(w.hit));
        if (out_hit_position !== w.hit_position)
          report_mismatch("hit_position", 32'(out_hit_position), 32'(w.hit_position));
        if (out_evicted_valid !== w.evicted_valid)
          report_mismatch("evicted_valid", 32'(out_evicted_valid), 32'(w.evicted_valid));
        if (out_evicted_page !== w.evicted_page)
          report_mismatch("evicted_page", out_evicted_page, w.evicted_page);
        if (out_evicted_dirty !== w.evicted_dirty)
          report_mismatch("evicted_dirty", 32'(out_evicted_dirty), 32'(w.evicted_dirty));
        if (out_hit_total !== w.hit_total)
          report_mismatch("hit_total", out_hit_total, w.hit_total);
        if (out_read_miss_total !== w.read_miss_total)
          report_mismatch("read_miss_total", out_read_miss_total, w.read_miss_total);
        if (out_write_miss_total !== w.write_miss_total)
          report_mismatch("write_miss_total", out_write_miss_total, w.write_miss_total);
      end
    end
  end

  // Receiver back-pressure, with one long hold-off on request.
  initial begin
    int r;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(0, 6)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (r < 92 ? $urandom_range(0, 3) : $urandom_range(10, 60)) @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Sender side idle gap length.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_access(logic op, logic [31:0] id, bit typed, access_result_t want);
    int gap;
    access_result_t p;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_page_id <= id;
    do @(posedge clk); while (!in_ready);
    p = predict_access(op, id);
    pending_results.insert(pending_results.size(), typed ? want : p);
    accesses++;
  endtask

  // Lets every outstanding result come back and the block settle.
  task automatic drain_pool();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_POLICY: pol_m = policy_t'(data[1:0]);
      CFG_CAPACITY: cap_m = data[4:0];
      CFG_DIVISOR: div_m = data[4:0];
      default: ;
    endcase
  endtask

  function automatic stim_row_t cfg_row(cfg_reg_t idx, logic [31:0] data);
    stim_row_t s;
    s.is_cfg = 1'b1;
    s.reg_index = idx;
    s.reg_data = data;
    s.op = 1'b0;
    s.page = '0;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_row_t acc_row(logic op, logic [31:0] id, bit typed,
                                        access_result_t want);
    stim_row_t s;
    s.is_cfg = 1'b0;
    s.reg_index = CFG_POLICY;
    s.reg_data = '0;
    s.op = op;
    s.page = id;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(stim_row_t s);
    table_rows.insert(table_rows.size(), s);
  endfunction

  initial begin
    access_result_t none;
    logic [31:0] base;
    logic [31:0] id;
    int span;
    none = '0;
    pol_m = POL_LRU;
    cap_m = 5'd16;
    div_m = 5'd4;
    occ_m = 0;
    hand_m = 0;
    hits_m = '0;
    rmiss_m = '0;
    wmiss_m = '0;
    for (int k = 0; k < DEPTH; k++) begin
      page_m[k] = '0;
      dirty_m[k] = 1'b0;
      visited_m[k] = 1'b0;
    end

    // Directed table: extremes of the id, each policy, and the corner settings.
    add_row(acc_row(1'b0, 32'h0, 1'b1,
      '{1'b0, 4'd0, 1'b0, 32'h0, 1'b0, 32'd0, 32'd1, 32'd0}));
    add_row(acc_row(1'b1, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, 4'd0, 1'b0, 32'h0, 1'b0, 32'd0, 32'd1, 32'd1}));
    add_row(acc_row(1'b0, 32'h0, 1'b1,
      '{1'b1, 4'd0, 1'b0, 32'h0, 1'b0, 32'd1, 32'd1, 32'd1}));
    add_row(acc_row(1'b1, 32'h0, 1'b1,
      '{1'b1, 4'd1, 1'b0, 32'h0, 1'b0, 32'd2, 32'd1, 32'd1}));
    add_row(cfg_row(CFG_CAPACITY, 32'd2));
    // LRU with a full pool evicts the oldest page, which is the dirty all-ones id.
    add_row(acc_row(1'b0, 32'h5, 1'b1,
      '{1'b0, 4'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'd2, 32'd2, 32'd1}));
    add_row(cfg_row(CFG_POLICY, 32'(POL_CFLRU)));
    add_row(cfg_row(CFG_DIVISOR, 32'd1));
    add_row(acc_row(1'b1, 32'h7, 1'b0, none));
    add_row(acc_row(1'b0, 32'h9, 1'b0, none));
    add_row(acc_row(1'b0, 32'h9, 1'b0, none));
    add_row(cfg_row(CFG_POLICY, 32'(POL_SIEVE)));
    add_row(cfg_row(CFG_CAPACITY, 32'd3));
    add_row(acc_row(1'b0, 32'h1, 1'b0, none));
    add_row(acc_row(1'b1, 32'h9, 1'b0, none));
    add_row(acc_row(1'b0, 32'h1, 1'b0, none));
    add_row(acc_row(1'b0, 32'h4, 1'b0, none));
    add_row(acc_row(1'b0, 32'h5, 1'b0, none));
    // Unused policy: counted but neither reordered nor inserted.
    add_row(cfg_row(CFG_POLICY, 32'(POL_NONE)));
    add_row(acc_row(1'b1, 32'h5, 1'b0, none));
    add_row(acc_row(1'b0, 32'h77, 1'b0, none));
    // Capacity zero acts as one, with the pool already above it.
    add_row(cfg_row(CFG_POLICY, 32'(POL_LRU)));
    add_row(cfg_row(CFG_CAPACITY, 32'd0));
    add_row(acc_row(1'b0, 32'h8, 1'b0, none));
    // Oversized capacity and a zero divisor.
    add_row(cfg_row(CFG_CAPACITY, 32'd31));
    add_row(cfg_row(CFG_DIVISOR, 32'd0));
    add_row(cfg_row(CFG_POLICY, 32'(POL_CFLRU)));
    add_row(acc_row(1'b1, 32'h8000_0000, 1'b0, none));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        drain_pool();
        write_reg(table_rows[i].reg_index, table_rows[i].reg_data);
      end else begin
        send_access(table_rows[i].op, table_rows[i].page, table_rows[i].typed,
                    table_rows[i].want);
      end
    end

    // Random phases: each one a new setting of every register.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_pool();
      write_reg(CFG_POLICY, (ph % 5 == 4) ? 32'(POL_NONE) : 32'(policy_t'(ph % 3)));
      write_reg(CFG_CAPACITY, (ph % 4 == 0) ? 32'd1 : (ph % 4 == 1) ? 32'd16 :
                              $urandom_range(0, 31));
      write_reg(CFG_DIVISOR, (ph % 4 == 2) ? 32'd16 : (ph % 4 == 3) ? 32'd1 :
                             $urandom_range(0, 31));
      no_gaps = (ph % 6 == 5);
      if (ph == 3) hold_req = 1'b1;
      base = (ph % 5 == 0) ? 32'hFFFF_FFE0 : (ph % 5 == 1) ? 32'h0 : $urandom;
      span = $urandom_range(4, 24);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        id = ($urandom_range(0, 7) == 0) ? $urandom : base + $urandom_range(0, span);
        send_access(1'($urandom_range(0, 1)), id, 1'b0, none);
      end
    end

    drain_pool();
    $display("run covered %0d accesses over %0d register settings, %0d results, %0d evictions",
             accesses, PHASES + 1, results_seen, evictions_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches found", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
